[rtl/attitude_table_linear_interp_defines.svh]
// Assertion macros for the checker file.
`ifndef ATTITUDE_TABLE_LINEAR_INTERP_DEFINES_SVH
`define ATTITUDE_TABLE_LINEAR_INTERP_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define ATI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define ATI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define ATI_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: reset check failed");

`endif

[rtl/attin_pkg.sv]
package attin_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 4096;
  localparam int ANGLE_W             = 32;
  localparam int TIME_W              = 48;
  localparam int PERIOD_W            = 32;
  localparam int COUNT_W             = 13;
  localparam int INDEX_W             = 12;
  localparam int QUEUE_DEPTH         = 64;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd65536;

  // register indexes
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  // request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BEFORE = 2'd1;
  localparam logic [1:0] ST_AFTER  = 2'd2;

  typedef struct packed {
    logic       is_load;
    logic       wr_ok;
    logic [1:0] status;
    logic [15:0] weight;
  } ctl_t;

endpackage

[rtl/attin_ram.sv]
module attin_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/attin_front.sv]
module attin_front
  import attin_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          acc,
  input  logic                          req_type,
  input  logic [INDEX_W-1:0]            sample_index,
  input  logic signed [ANGLE_W-1:0]     roll_in,
  input  logic signed [ANGLE_W-1:0]     pitch_in,
  input  logic signed [ANGLE_W-1:0]     yaw_in,
  input  logic signed [TIME_W-1:0]      query_time,
  input  logic [PERIOD_W-1:0]           period,
  input  logic [COUNT_W-1:0]            count,
  output logic                          q_we,
  output ctl_t                          q_ctl,
  output logic [$clog2(TABLE_DEPTH)-1:0] q_addr,
  output logic [ANGLE_W-1:0]            q_roll,
  output logic [ANGLE_W-1:0]            q_pitch,
  output logic [ANGLE_W-1:0]            q_yaw
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int QB = IW + 16;   // quotient bits: index and weight
  localparam int CW = 18;        // compare width for index against count

  logic              v      [0:QB];
  logic              typ    [0:QB];
  logic              neg    [0:QB];
  logic              big    [0:QB];
  logic              idx_ok [0:QB];
  logic [IW-1:0]     waddr  [0:QB];
  logic [ANGLE_W-1:0] ro    [0:QB];
  logic [ANGLE_W-1:0] pi    [0:QB];
  logic [ANGLE_W-1:0] ya    [0:QB];
  logic [PERIOD_W-1:0] rem  [0:QB];
  logic [QB-1:0]     nb     [0:QB];

  logic [TIME_W-1:0]  t_hi;
  logic               big_in;
  logic [IW+11:0]     idx_ext;

  // quotient above the index range means the query is past the table
  assign t_hi    = TIME_W'(query_time[TIME_W-2:0]) >> IW;
  assign big_in  = t_hi >= TIME_W'(period);
  assign idx_ext = (IW+12)'(sample_index);

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= acc;
    end
  end

  always_ff @(posedge clk) begin
    typ[0]    <= req_type;
    neg[0]    <= query_time[TIME_W-1];
    big[0]    <= big_in;
    idx_ok[0] <= 32'(sample_index) < 32'(TABLE_DEPTH);
    waddr[0]  <= idx_ext[IW-1:0];
    ro[0]     <= roll_in;
    pi[0]     <= pitch_in;
    ya[0]     <= yaw_in;
    rem[0]    <= t_hi[PERIOD_W-1:0];
    nb[0]     <= {query_time[IW-1:0], 16'b0};
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [PERIOD_W:0] trial;
    logic [PERIOD_W:0] diff;
    logic              ge;

    assign trial = {rem[k], nb[k][QB-1]};
    assign diff  = trial - {1'b0, period};
    assign ge    = trial >= {1'b0, period};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      typ[k+1]    <= typ[k];
      neg[k+1]    <= neg[k];
      big[k+1]    <= big[k];
      idx_ok[k+1] <= idx_ok[k];
      waddr[k+1]  <= waddr[k];
      ro[k+1]     <= ro[k];
      pi[k+1]     <= pi[k];
      ya[k+1]     <= ya[k];
      rem[k+1]    <= ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      nb[k+1]     <= {nb[k][QB-2:0], ge};
    end
  end

  logic [IW-1:0] i1;
  logic [CW-1:0] i2;
  logic [CW-1:0] cnt_eff;

  // classify the finished word
  assign i1      = nb[QB][QB-1:16];
  assign i2      = CW'(i1) + CW'(1);
  assign cnt_eff = (CW'(count) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count);

  always_comb begin
    q_ctl.is_load = typ[QB] == REQ_LOAD;
    q_ctl.wr_ok   = idx_ok[QB];
    q_ctl.weight  = nb[QB][15:0];
    if (typ[QB] == REQ_LOAD) begin
      q_ctl.status = ST_OK;
    end else if (neg[QB]) begin
      q_ctl.status = ST_BEFORE;
    end else if (big[QB] || (i2 >= cnt_eff)) begin
      q_ctl.status = ST_AFTER;
    end else begin
      q_ctl.status = ST_OK;
    end
  end

  assign q_we    = v[QB];
  assign q_addr  = (typ[QB] == REQ_LOAD) ? waddr[QB] : i1;
  assign q_roll  = ro[QB];
  assign q_pitch = pi[QB];
  assign q_yaw   = ya[QB];

endmodule

[rtl/attin_queue.sv]
module attin_queue
  import attin_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic             we,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             nonempty,
  output logic             room,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   fill;
  logic [AW:0]   credits;

  // credits cover words still in the front pipe plus words stored here
  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + (AW+1)'(take) - (AW+1)'(pop);
    end
  end

  // advance pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (we) begin
        wptr <= wptr + AW'(1);
      end
      if (pop) begin
        rptr <= rptr + AW'(1);
      end
      fill <= fill + (AW+1)'(we) - (AW+1)'(pop);
    end
  end

  assign nonempty = fill != '0;
  assign room     = credits < (AW+1)'(QUEUE_DEPTH);

  attin_ram #(
    .WIDTH(WIDTH),
    .DEPTH(QUEUE_DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(wptr),
    .wdata(wdata),
    .re   (pop),
    .raddr(rptr),
    .rdata(rdata)
  );

endmodule

[rtl/attin_back.sv]
module attin_back
  import attin_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      nonempty,
  output logic                      pop,
  input  logic [$bits(ctl_t)+$clog2(TABLE_DEPTH)+3*ANGLE_W-1:0] qdata,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [1:0]                status,
  output logic signed [ANGLE_W-1:0] roll_out,
  output logic signed [ANGLE_W-1:0] pitch_out,
  output logic signed [ANGLE_W-1:0] yaw_out
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int PW = ANGLE_W + 18;

  logic          en;
  logic          v1, v2, v3;
  ctl_t          ctl1, ctl2, ctl3;
  logic [IW-1:0] addr1;
  logic [ANGLE_W-1:0] wval [3];
  logic [ANGLE_W-1:0] rd_a [3];
  logic [ANGLE_W-1:0] rd_b [3];
  logic [ANGLE_W-1:0] a3   [3];
  logic signed [PW-1:0] p3 [3];
  logic [ANGLE_W-1:0] ang  [3];
  logic          tbl_we;

  // the whole back half moves unless the output word is stuck
  assign en  = !out_valid || out_ready;
  assign pop = en && nonempty;

  assign {ctl1, addr1, wval[0], wval[1], wval[2]} = qdata;
  assign tbl_we = en && v1 && ctl1.is_load && ctl1.wr_ok;

  // valid bits through the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= pop;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl2 <= ctl1;
      ctl3 <= ctl2;
    end
  end

  // one table per angle, two copies for the left and right reads
  for (genvar g = 0; g < 3; g++) begin : g_ang
    logic signed [ANGLE_W:0] d;

    attin_ram #(
      .WIDTH(ANGLE_W),
      .DEPTH(TABLE_DEPTH)
    ) u_left (
      .clk  (clk),
      .we   (tbl_we),
      .waddr(addr1),
      .wdata(wval[g]),
      .re   (en),
      .raddr(addr1),
      .rdata(rd_a[g])
    );

    attin_ram #(
      .WIDTH(ANGLE_W),
      .DEPTH(TABLE_DEPTH)
    ) u_right (
      .clk  (clk),
      .we   (tbl_we),
      .waddr(addr1),
      .wdata(wval[g]),
      .re   (en),
      .raddr(addr1 + IW'(1)),
      .rdata(rd_b[g])
    );

    // difference of the right and left samples
    assign d = $signed({rd_b[g][ANGLE_W-1], rd_b[g]}) - $signed({rd_a[g][ANGLE_W-1], rd_a[g]});

    always_ff @(posedge clk) begin
      if (en) begin
        a3[g] <= rd_a[g];
        p3[g] <= d * $signed({1'b0, ctl2.weight});
      end
    end

    // floor of the product by 2^16, added to the left sample; zero for loads and errors
    always_ff @(posedge clk) begin
      if (en) begin
        if (ctl3.is_load || ctl3.status != ST_OK) begin
          ang[g] <= '0;
        end else begin
          ang[g] <= a3[g] + p3[g][ANGLE_W+15:16];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status <= ctl3.status;
    end
  end

  assign roll_out  = ang[0];
  assign pitch_out = ang[1];
  assign yaw_out   = ang[2];

endmodule

[rtl/attitude_table_linear_interp.sv]
// Attitude table with uniform-period linear interpolation.
// Input channel (in_valid/in_ready): req_type selects a load, which writes
// roll/pitch/yaw at sample_index, or a query, which interpolates all three
// angles at query_time. Every word returns exactly one result word on the
// output channel (out_valid/out_ready) in acceptance order.
// Configuration: cfg_we writes cfg_data into sample_period (index 0) or
// the sample count (index 1); write only while the block is idle.
// The divider is a restoring divider that yields one quotient bit per stage.
// Throughput is one word per cycle while the output is taken.
// A 64-entry queue sits between divider and table lookup; when the receiver
// stalls, the lookup side holds and the queue absorbs words until its
// credits run out, then in_ready drops.
// Reset empties all pipes, sets the period to 65536 and the count to 0;
// the tables keep their contents and hold nothing defined until loaded.
module attitude_table_linear_interp
  import attin_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [PERIOD_W-1:0]       cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      req_type,
  input  logic [INDEX_W-1:0]        sample_index,
  input  logic signed [ANGLE_W-1:0] roll_in,
  input  logic signed [ANGLE_W-1:0] pitch_in,
  input  logic signed [ANGLE_W-1:0] yaw_in,
  input  logic signed [TIME_W-1:0]  query_time,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status,
  output logic signed [ANGLE_W-1:0] roll_out,
  output logic signed [ANGLE_W-1:0] pitch_out,
  output logic signed [ANGLE_W-1:0] yaw_out
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int QW = $bits(ctl_t) + IW + 3*ANGLE_W;

  logic [PERIOD_W-1:0] sample_period;
  logic [COUNT_W-1:0]  num_samples;
  logic [PERIOD_W-1:0] period_eff;
  logic                acc;
  logic                q_we;
  ctl_t                q_ctl;
  logic [IW-1:0]       q_addr;
  logic [ANGLE_W-1:0]  q_roll, q_pitch, q_yaw;
  logic [QW-1:0]       q_wdata;
  logic [QW-1:0]       q_rdata;
  logic                q_pop;
  logic                q_nonempty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= PERIOD_RESET;
      num_samples   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD: sample_period <= cfg_data;
        REG_COUNT:  num_samples   <= cfg_data[COUNT_W-1:0];
        default:    num_samples   <= num_samples;
      endcase
    end
  end

  // a zero period acts as one
  assign period_eff = (sample_period == '0) ? PERIOD_W'(1) : sample_period;
  assign acc        = in_valid && in_ready;

  attin_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc),
    .req_type    (req_type),
    .sample_index(sample_index),
    .roll_in     (roll_in),
    .pitch_in    (pitch_in),
    .yaw_in      (yaw_in),
    .query_time  (query_time),
    .period      (period_eff),
    .count       (num_samples),
    .q_we        (q_we),
    .q_ctl       (q_ctl),
    .q_addr      (q_addr),
    .q_roll      (q_roll),
    .q_pitch     (q_pitch),
    .q_yaw       (q_yaw)
  );

  assign q_wdata = {q_ctl, q_addr, q_roll, q_pitch, q_yaw};

  attin_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .take    (acc),
    .we      (q_we),
    .wdata   (q_wdata),
    .pop     (q_pop),
    .nonempty(q_nonempty),
    .room    (in_ready),
    .rdata   (q_rdata)
  );

  attin_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (q_nonempty),
    .pop      (q_pop),
    .qdata    (q_rdata),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .status   (status),
    .roll_out (roll_out),
    .pitch_out(pitch_out),
    .yaw_out  (yaw_out)
  );

endmodule

[rtl/attin_chk.sv]
`include "attitude_table_linear_interp_defines.svh"

module attin_chk
  import attin_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                status,
  input logic signed [ANGLE_W-1:0] roll_out,
  input logic signed [ANGLE_W-1:0] pitch_out,
  input logic signed [ANGLE_W-1:0] yaw_out
);

  // no result word right after reset
  `ATI_ASSERT_ALWAYS(a_rst_empty, rst, !out_valid)

  // a stalled result word keeps its status and roll angle
  `ATI_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(roll_out))

  // only defined status codes leave the block
  `ATI_ASSERT_NOW(a_status, out_valid, status == ST_OK || status == ST_BEFORE || status == ST_AFTER)

  // an error word carries zero angles
  `ATI_ASSERT_NOW(a_err_zero, out_valid && status != ST_OK, roll_out == '0 && pitch_out == '0 && yaw_out == '0)

endmodule

bind attitude_table_linear_interp attin_chk u_chk (.*);
